/* rtl/wsl_pkg.sv */
// Package: weighted sound level types, curve constants and log helpers
package wsl_pkg;

	localparam logic [2:0] SEL_NONE = 3'd0;
	localparam logic [2:0] SEL_A    = 3'd1;
	localparam logic [2:0] SEL_B    = 3'd2;
	localparam logic [2:0] SEL_C    = 3'd3;
	localparam logic [2:0] SEL_D    = 3'd4;

	localparam logic CFG_WSEL = 1'b0;
	localparam logic CFG_REF  = 1'b1;

	localparam logic [63:0] C1  = 64'd609049133056;
	localparam logic [63:0] C2  = 64'd1738179;
	localparam logic [63:0] C3  = 64'd47510692;
	localparam logic [63:0] C4  = 64'd2242363433;
	localparam logic [63:0] C3B = 64'd102900736;
	localparam logic [63:0] DA  = 64'd327349412;
	localparam logic [63:0] DB  = 64'd5511577600;
	localparam logic [63:0] D1  = 64'd4251314094;
	localparam logic [63:0] E1  = 64'd4426826383;
	localparam logic [63:0] D2  = 64'd40293695488;
	localparam logic [63:0] E2  = 64'd48020586496;
	localparam logic [63:0] DK  = 64'd861149754834;
	localparam logic [63:0] U1K = 64'd4096000000;

	localparam int LG_STEPS = 16;

	// leading one index of a 128-bit value and its 32-bit normalized mantissa
	typedef struct packed {
		logic [6:0]  p;
		logic [31:0] m;
	} lg_norm_t;

	function automatic lg_norm_t lg_normalize(input logic [127:0] x);
		lg_norm_t   r;
		logic [6:0] p;
		logic [158:0] ext;
		p = 7'd0;
		for (int i = 0; i < 128; i++) begin
			if (x[i]) p = 7'(i);
		end
		ext = {x, 31'd0};
		r.p = p;
		r.m = ext[p +: 32];
		return r;
	endfunction

	// one fraction bit of the squaring log
	typedef struct packed {
		logic [31:0] m;
		logic        b;
	} lg_bit_t;

	function automatic lg_bit_t lg_step(input logic [31:0] m);
		lg_bit_t r;
		logic [63:0] sq;
		logic [32:0] t;
		sq = 64'(m) * 64'(m);
		t = sq[63:31];
		r.b = t[32];
		r.m = t[32] ? t[32:1] : t[31:0];
		return r;
	endfunction

	// full log of a fixed value, for constants
	function automatic logic signed [31:0] lg_const(input logic [127:0] x);
		lg_norm_t    n;
		lg_bit_t     st;
		logic [31:0] m;
		logic [15:0] f;
		n = lg_normalize(x);
		m = n.m;
		f = 16'd0;
		for (int i = 0; i < LG_STEPS; i++) begin
			st = lg_step(m);
			m = st.m;
			f = {f[14:0], st.b};
		end
		return (x == 128'd0) ? 32'sd0 : $signed({9'd0, n.p, f});
	endfunction

	// log2 in Q.16 of fixed constants
	localparam logic signed [31:0] LG_1E12 = lg_const(128'd1000000000000);
	localparam logic signed [31:0] LG_DK   = lg_const(128'(DK));
	localparam logic signed [31:0] TA_1K   = 4 * lg_const(128'(U1K))
		- 2 * lg_const(128'(U1K + C2)) - lg_const(128'(U1K + C3))
		- lg_const(128'(U1K + C4)) - 2 * lg_const(128'(U1K + C1));
	localparam logic signed [31:0] TB_1K   = 3 * lg_const(128'(U1K))
		- 2 * lg_const(128'(U1K + C2)) - lg_const(128'(U1K + C3B))
		- 2 * lg_const(128'(U1K + C1));
	localparam logic signed [31:0] TC_1K   = 2 * lg_const(128'(U1K))
		- 2 * lg_const(128'(U1K + C2)) - 2 * lg_const(128'(U1K + C1));
	localparam logic signed [31:0] DB_PER_LOG2 = 32'sd197283;

endpackage

/* rtl/wsl_log.sv */
// Module: pipelined base-2 log unit, Q.16 result, one fraction bit per stage
module wsl_log (
	input  logic               clk,
	input  logic               en,
	input  logic [127:0]       x,
	output logic signed [31:0] lg
);
	localparam int N = wsl_pkg::LG_STEPS;

	logic [6:0]  p_s   [N+1];
	logic [31:0] m_s   [N+1];
	logic [15:0] f_s   [N+1];
	logic        z_s   [N+1];
	wsl_pkg::lg_norm_t nrm;

	assign nrm = wsl_pkg::lg_normalize(x);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0] <= nrm.p;
			m_s[0] <= nrm.m;
			f_s[0] <= 16'd0;
			z_s[0] <= (x == 128'd0);
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_stage
		wsl_pkg::lg_bit_t st;
		assign st = wsl_pkg::lg_step(m_s[g]);
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[g+1] <= p_s[g];
				m_s[g+1] <= st.m;
				f_s[g+1] <= {f_s[g][14:0], st.b};
				z_s[g+1] <= z_s[g];
			end
		end
	end

	assign lg = z_s[N] ? 32'sd0 : $signed({9'd0, p_s[N], f_s[N]});
endmodule

/* rtl/weighted_sound_level_top.sv */
// Module: weighted sound level top level, log pipeline and output register
//
//  channel   dir  handshake          payload
//  cfg       in   cfg_valid/ready    cfg_index, cfg_data
//  in        in   in_valid/ready     pressure_sq, frequency
//  out       out  out_valid/ready    level_db, floored
//
// One bin per cycle unless the output stalls; 25 register stages: four for
// the square, distances, partial products and quadratic sums, 17 in the log
// pipeline, then sum, scaling, saturation and output. All stages advance
// together when the output register is free or taken; a stall holds every
// stage. Reset clears valid bits and sets the registers to no weighting and
// 20 uPa.
module weighted_sound_level_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [47:0]        pressure_sq,
	input  logic [23:0]        frequency,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] level_db,
	output logic               floored
);
	localparam int NL  = 8;
	localparam int LAT = wsl_pkg::LG_STEPS + 1;
	localparam int DEP = LAT + 8;

	logic [2:0]  wsel_q;
	logic [19:0] ref_q;
	logic        adv;
	logic [DEP-1:0] v_s;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= wsl_pkg::SEL_NONE;
			ref_q  <= 20'd20;
		end else if (cfg_valid) begin
			if (cfg_index == wsl_pkg::CFG_WSEL) wsel_q <= cfg_data[2:0];
			else ref_q <= cfg_data;
		end
	end

	// stage 1: u = f^2, reference
	logic [47:0] p2_s1;
	logic [47:0] u_s1;
	logic [19:0] ref_s1;
	logic [2:0]  sel_s1;
	logic        fz_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s1  <= pressure_sq;
			u_s1   <= 48'(frequency) * 48'(frequency);
			ref_s1 <= (ref_q == 20'd0) ? 20'd1 : ref_q;
			sel_s1 <= wsel_q;
			fz_s1  <= (frequency == 24'd0);
		end
	end

	// stage 2: distances from the quadratic roots
	logic [47:0] dif1, dif2;
	assign dif1 = (u_s1 >= wsl_pkg::D1[47:0]) ? u_s1 - wsl_pkg::D1[47:0] :
	              wsl_pkg::D1[47:0] - u_s1;
	assign dif2 = (u_s1 >= wsl_pkg::D2[47:0]) ? u_s1 - wsl_pkg::D2[47:0] :
	              wsl_pkg::D2[47:0] - u_s1;

	logic [47:0] p2_s2, u_s2;
	logic [19:0] ref_s2;
	logic [2:0]  sel_s2;
	logic        fz_s2;
	logic [47:0] dif1_s2, dif2_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s2 <= p2_s1; u_s2 <= u_s1; ref_s2 <= ref_s1;
			sel_s2 <= sel_s1; fz_s2 <= fz_s1;
			dif1_s2 <= dif1; dif2_s2 <= dif2;
		end
	end

	// stage 3: quadratic product partials
	logic [47:0] hh1_s3, hl1_s3, ll1_s3, hh2_s3, hl2_s3, ll2_s3;
	logic [59:0] eh1_s3, el1_s3, eh2_s3, el2_s3;
	logic [47:0] p2_s3, u_s3;
	logic [19:0] ref_s3;
	logic [2:0]  sel_s3;
	logic        fz_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			hh1_s3 <= 48'(dif1_s2[47:24]) * 48'(dif1_s2[47:24]);
			hl1_s3 <= 48'(dif1_s2[47:24]) * 48'(dif1_s2[23:0]);
			ll1_s3 <= 48'(dif1_s2[23:0]) * 48'(dif1_s2[23:0]);
			hh2_s3 <= 48'(dif2_s2[47:24]) * 48'(dif2_s2[47:24]);
			hl2_s3 <= 48'(dif2_s2[47:24]) * 48'(dif2_s2[23:0]);
			ll2_s3 <= 48'(dif2_s2[23:0]) * 48'(dif2_s2[23:0]);
			eh1_s3 <= 60'(wsl_pkg::E1[35:0]) * 60'(u_s2[47:24]);
			el1_s3 <= 60'(wsl_pkg::E1[35:0]) * 60'(u_s2[23:0]);
			eh2_s3 <= 60'(wsl_pkg::E2[35:0]) * 60'(u_s2[47:24]);
			el2_s3 <= 60'(wsl_pkg::E2[35:0]) * 60'(u_s2[23:0]);
			p2_s3 <= p2_s2; u_s3 <= u_s2; ref_s3 <= ref_s2;
			sel_s3 <= sel_s2; fz_s3 <= fz_s2;
		end
	end

	// stage 4: quadratic sums
	logic [127:0] n_s4, m_s4;
	logic [47:0]  p2_s4, u_s4;
	logic [19:0]  ref_s4;
	logic [2:0]   sel_s4;
	logic         fz_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			n_s4 <= (128'(hh1_s3) << 48) + (128'(hl1_s3) << 25) + 128'(ll1_s3)
				+ (128'(eh1_s3) << 24) + 128'(el1_s3);
			m_s4 <= (128'(hh2_s3) << 48) + (128'(hl2_s3) << 25) + 128'(ll2_s3)
				+ (128'(eh2_s3) << 24) + 128'(el2_s3);
			p2_s4 <= p2_s3; u_s4 <= u_s3; ref_s4 <= ref_s3;
			sel_s4 <= sel_s3; fz_s4 <= fz_s3;
		end
	end

	// log lane inputs
	logic [127:0] lx [NL];
	logic [63:0]  u3;
	assign u3 = 64'(u_s4);
	always_comb begin
		lx[0] = 128'(p2_s4);
		lx[1] = 128'(ref_s4);
		lx[2] = 128'(u3);
		lx[3] = 128'(u3 + wsl_pkg::C2);
		lx[4] = 128'(u3 + wsl_pkg::C1);
		lx[5] = (sel_s4 == wsl_pkg::SEL_A) ? 128'(u3 + wsl_pkg::C3) :
		        (sel_s4 == wsl_pkg::SEL_B) ? 128'(u3 + wsl_pkg::C3B) :
		        128'(u3 + wsl_pkg::DA);
		lx[6] = (sel_s4 == wsl_pkg::SEL_D) ? 128'(u3 + wsl_pkg::DB) :
		        128'(u3 + wsl_pkg::C4);
		lx[7] = n_s4;
	end

	logic signed [31:0] lg [NL];
	for (genvar g = 0; g < NL; g++) begin : g_log
		wsl_log u_log (.clk(clk), .en(adv), .x(lx[g]), .lg(lg[g]));
	end
	logic signed [31:0] lg_m;
	wsl_log u_log_m (.clk(clk), .en(adv), .x(m_s4), .lg(lg_m));

	// side data delayed alongside the log pipeline
	logic [2:0] sel_d [LAT];
	logic       fz_d  [LAT];
	logic       pz_d  [LAT+3];
	always_ff @(posedge clk) begin
		if (adv) begin
			sel_d[0] <= sel_s4;
			fz_d[0]  <= fz_s4;
			for (int i = 1; i < LAT; i++) begin
				sel_d[i] <= sel_d[i-1];
				fz_d[i]  <= fz_d[i-1];
			end
			pz_d[0] <= (p2_s4 == 48'd0);
			for (int i = 1; i < LAT + 3; i++) pz_d[i] <= pz_d[i-1];
		end
	end

	// sum stage
	logic signed [31:0] base, w;
	always_comb begin
		base = lg[0] - 32'sd2097152 + wsl_pkg::LG_1E12 - 2 * lg[1];
		case (sel_d[LAT-1])
			wsl_pkg::SEL_A: w = 4*lg[2] - 2*lg[3] - lg[5] - lg[6] - 2*lg[4] - wsl_pkg::TA_1K;
			wsl_pkg::SEL_B: w = 3*lg[2] - 2*lg[3] - lg[5] - 2*lg[4] - wsl_pkg::TB_1K;
			wsl_pkg::SEL_C: w = 2*lg[2] - 2*lg[3] - 2*lg[4] - wsl_pkg::TC_1K;
			wsl_pkg::SEL_D: w = lg[2] + lg[7] - lg_m - lg[5] - lg[6] + wsl_pkg::LG_DK;
			default:        w = 32'sd0;
		endcase
		if (fz_d[LAT-1]) w = 32'sd0;
	end

	logic signed [31:0] s_s4;
	logic signed [55:0] v_s5;
	logic signed [15:0] q_s6;
	logic signed [31:0] qq;
	always_comb begin
		qq = 32'(v_s5 >>> 24);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s4 <= base + w;
			v_s5 <= 56'(s_s4) * 56'(wsl_pkg::DB_PER_LOG2) + 56'sd8388608;
			if (qq > 32'sd32767) q_s6 <= 16'sh7fff;
			else if (qq < -32'sd32768) q_s6 <= 16'sh8000;
			else q_s6 <= qq[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[DEP-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_db <= pz_d[LAT+2] ? 16'sh8000 : q_s6;
			floored  <= pz_d[LAT+2];
		end
	end

	assign out_valid = v_s[DEP-1];
endmodule
